[rtl/packet_field_modifier_defines.svh]
// Assertion macros shared by the packet field modifier modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef PACKET_FIELD_MODIFIER_DEFINES_SVH
`define PACKET_FIELD_MODIFIER_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define PFM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PFM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pfm_pkg.sv]
// Package of the packet field modifier: transfer payload types, configuration
// record, register indexes and code constants. No dependencies.
package pfm_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [30:0] frame_index;
        logic        last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic [10:0] field_offset;
        logic [1:0]  field_width_sel;
        logic [1:0]  vary_mode;
        logic [31:0] start_value;
        logic [31:0] step_size;
        logic [31:0] repeat_count;
        logic [31:0] field_mask;
        logic [11:0] header_length;
    } cfg_t;

    localparam logic [2:0] REG_FIELD_OFFSET    = 3'd0;
    localparam logic [2:0] REG_FIELD_WIDTH_SEL = 3'd1;
    localparam logic [2:0] REG_VARY_MODE       = 3'd2;
    localparam logic [2:0] REG_START_VALUE     = 3'd3;
    localparam logic [2:0] REG_STEP_SIZE       = 3'd4;
    localparam logic [2:0] REG_REPEAT_COUNT    = 3'd5;
    localparam logic [2:0] REG_FIELD_MASK      = 3'd6;
    localparam logic [2:0] REG_HEADER_LENGTH   = 3'd7;

    localparam logic [1:0] WIDTH_8BIT  = 2'd0;
    localparam logic [1:0] WIDTH_16BIT = 2'd1;
    localparam logic [1:0] WIDTH_32BIT = 2'd2;
    localparam logic [1:0] WIDTH_NONE  = 2'd3;

    localparam logic [1:0] MODE_INCREMENT = 2'd0;
    localparam logic [1:0] MODE_DECREMENT = 2'd1;
    localparam logic [1:0] MODE_RANDOM    = 2'd2;
    localparam logic [1:0] MODE_NONE      = 2'd3;

    localparam logic [31:0] LFSR_TAPS = 32'hB4BC_D35C;
    localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

    localparam cfg_t CFG_RESET = '{
        field_offset:    11'd0,
        field_width_sel: WIDTH_NONE,
        vary_mode:       MODE_INCREMENT,
        start_value:     32'd0,
        step_size:       32'd1,
        repeat_count:    32'd1,
        field_mask:      32'hFFFF_FFFF,
        header_length:   12'd64
    };

endpackage

[rtl/pfm_addsub.sv]
// Shared 33-bit adder and subtractor of the packet field modifier.
// Used by the value sequencer for division, multiplication and the final sum or difference.
module pfm_addsub (
    input  logic [32:0] op_a,
    input  logic [32:0] op_b,
    input  logic        sub,
    output logic [33:0] result
);
    assign result = sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});
endmodule

[rtl/pfm_calc.sv]
// Per-frame field value sequencer: restoring division for the frame modulo,
// shift-add multiplication by the step and the final sum or difference, all on pfm_addsub.
// Depends on pfm_pkg, pfm_addsub and packet_field_modifier_defines.svh.
`include "packet_field_modifier_defines.svh"

module pfm_calc (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [30:0]  frame_index,
    input  pfm_pkg::cfg_t cfg,
    input  logic [31:0]  lfsr,
    output logic         done,
    output logic [31:0]  value
);
    import pfm_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_DIV  = 4'b0010,
        C_MUL  = 4'b0100,
        C_FIN  = 4'b1000
    } calc_state_t;

    calc_state_t state_reg, state_next;
    logic [30:0] dividend_reg, dividend_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] mcand_reg, mcand_next;
    logic [4:0]  count_reg, count_next;
    logic [31:0] value_reg, value_next;

    logic [31:0] cnt_eff;
    logic [31:0] wmask;
    logic [32:0] op_a, op_b;
    logic        op_sub;
    logic [33:0] op_result;

    assign cnt_eff = (cfg.repeat_count == 32'd0) ? 32'd1 : cfg.repeat_count;

    always_comb
    begin
        case (cfg.field_width_sel)
            WIDTH_8BIT:  wmask = 32'h0000_00FF;
            WIDTH_16BIT: wmask = 32'h0000_FFFF;
            WIDTH_32BIT: wmask = 32'hFFFF_FFFF;
            default:     wmask = 32'h0000_0000;
        endcase
    end

    always_comb
    begin
        op_a   = {rem_reg, dividend_reg[30]};
        op_b   = {1'b0, cnt_eff};
        op_sub = 1'b1;
        case (state_reg)
            C_MUL:
            begin
                op_a   = {1'b0, acc_reg};
                op_b   = {1'b0, mcand_reg};
                op_sub = 1'b0;
            end
            C_FIN:
            begin
                op_a   = {1'b0, cfg.start_value};
                op_b   = (cfg.vary_mode == MODE_INCREMENT || cfg.vary_mode == MODE_DECREMENT)
                         ? {1'b0, acc_reg} : {1'b0, lfsr};
                op_sub = (cfg.vary_mode == MODE_DECREMENT);
            end
            default:
            begin
            end
        endcase
    end

    pfm_addsub u_addsub (
        .op_a   (op_a),
        .op_b   (op_b),
        .sub    (op_sub),
        .result (op_result)
    );

    always_comb
    begin
        state_next    = state_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        count_next    = count_reg;
        value_next    = value_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    dividend_next = frame_index;
                    rem_next      = 32'd0;
                    count_next    = 5'd30;
                    state_next    = C_DIV;
                end
            end
            C_DIV:
            begin
                dividend_next = {dividend_reg[29:0], 1'b0};
                rem_next      = op_result[33] ? op_a[31:0] : op_result[31:0];
                count_next    = count_reg - 5'd1;
                if (count_reg == 5'd0)
                begin
                    acc_next   = 32'd0;
                    mcand_next = cfg.step_size;
                    count_next = 5'd31;
                    state_next = C_MUL;
                end
            end
            C_MUL:
            begin
                if (rem_reg[0])
                begin
                    acc_next = op_result[31:0];
                end
                rem_next   = {1'b0, rem_reg[31:1]};
                mcand_next = {mcand_reg[30:0], 1'b0};
                count_next = count_reg - 5'd1;
                if (count_reg == 5'd0)
                begin
                    state_next = C_FIN;
                end
            end
            C_FIN:
            begin
                value_next = op_result[31:0] & cfg.field_mask & wmask;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            count_reg <= 5'd0;
            value_reg <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            value_reg <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
    end

    assign done  = (state_reg == C_FIN);
    assign value = value_reg;

    `PFM_ASSERT_ALWAYS(a_calc_onehot, $onehot(state_reg), "calc state not one-hot")
    `PFM_ASSERT_SAME(a_rem_below_count, state_reg == C_DIV, rem_reg < cnt_eff,
        "partial remainder not below count")
    `PFM_ASSERT_NEXT(a_fin_to_idle, state_reg == C_FIN, state_reg == C_IDLE,
        "sequencer did not return to idle after finishing")

endmodule

[rtl/packet_field_modifier.sv]
// The first byte of a frame waits while the field value is computed by the 31-step
// division and 32-step multiplication on one shared adder; other bytes need no computation.
// One byte per cycle within a frame unless the output stalls; each frame start stalls input.
// Reset (rst_n, asynchronous, active low) restores register defaults, clears the byte
// position and field value, and seeds the random generator with one.
// Depends on pfm_pkg, pfm_calc, pfm_addsub and packet_field_modifier_defines.svh.
`include "packet_field_modifier_defines.svh"

module packet_field_modifier #(
    parameter int unsigned MAX_HEADER_BYTES = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  pfm_pkg::in_item_t    src_item,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output pfm_pkg::out_item_t   dst_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import pfm_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_HEADER_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } top_state_t;

    top_state_t  state_reg, state_next;
    cfg_t        cfg_reg, cfg_next;
    in_item_t    item_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic        value_ready_reg, value_ready_next;
    logic [31:0] lfsr_reg, lfsr_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    logic        accept;
    logic        slot_free;
    logic        commit;
    logic        calc_done;
    logic [31:0] field_value;
    in_item_t    cur_item;
    logic [7:0]  merged_byte;

    assign accept    = src_valid && !src_stall;
    assign src_stall = (state_reg != ST_IDLE);
    assign slot_free = !out_valid_reg || !dst_stall;
    assign cfg_ready = 1'b1;
    assign cur_item  = (state_reg == ST_IDLE) ? src_item : item_reg;
    assign commit    = (accept && value_ready_reg && slot_free) ||
                       (state_reg == ST_EMIT && slot_free);

    pfm_calc u_calc (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept && !value_ready_reg),
        .frame_index (src_item.frame_index),
        .cfg         (cfg_reg),
        .lfsr        (lfsr_reg),
        .done        (calc_done),
        .value       (field_value)
    );

    always_comb
    begin
        logic [2:0]  nb;
        logic [31:0] hlen;
        logic [31:0] off;
        logic [31:0] pos;
        logic [31:0] lane_full;
        logic [1:0]  lane;
        logic [7:0]  m;
        logic [7:0]  nv;
        case (cfg_reg.field_width_sel)
            WIDTH_8BIT:  nb = 3'd1;
            WIDTH_16BIT: nb = 3'd2;
            WIDTH_32BIT: nb = 3'd4;
            default:     nb = 3'd0;
        endcase
        hlen = (32'(cfg_reg.header_length) > 32'(MAX_HEADER_BYTES))
               ? 32'(MAX_HEADER_BYTES) : 32'(cfg_reg.header_length);
        off       = 32'(cfg_reg.field_offset);
        pos       = 32'(pos_reg);
        lane_full = 32'(nb) - 32'd1 - (pos - off);
        lane      = lane_full[1:0];
        m         = cfg_reg.field_mask[{lane, 3'b000} +: 8];
        nv        = field_value[{lane, 3'b000} +: 8];
        merged_byte = cur_item.data_byte;
        if (nb != 3'd0 && cfg_reg.vary_mode != MODE_NONE && off + 32'(nb) <= hlen &&
            pos >= off && pos < off + 32'(nb))
        begin
            merged_byte = (cur_item.data_byte & ~m) | (nv & m);
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FIELD_OFFSET:    cfg_next.field_offset    = cfg_data[10:0];
                REG_FIELD_WIDTH_SEL: cfg_next.field_width_sel = cfg_data[1:0];
                REG_VARY_MODE:       cfg_next.vary_mode       = cfg_data[1:0];
                REG_START_VALUE:     cfg_next.start_value     = cfg_data;
                REG_STEP_SIZE:       cfg_next.step_size       = cfg_data;
                REG_REPEAT_COUNT:    cfg_next.repeat_count    = cfg_data;
                REG_FIELD_MASK:      cfg_next.field_mask      = cfg_data;
                REG_HEADER_LENGTH:   cfg_next.header_length   = cfg_data[11:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        value_ready_next = value_ready_reg;
        lfsr_next        = lfsr_reg;
        out_valid_next   = out_valid_reg && dst_stall;
        out_next         = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!value_ready_reg)
                    begin
                        lfsr_next  = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : 32'd0);
                        state_next = ST_CALC;
                    end
                    else if (!slot_free)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CALC:
            begin
                if (calc_done)
                begin
                    value_ready_next = 1'b1;
                    state_next       = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (commit)
        begin
            out_valid_next    = 1'b1;
            out_next.out_byte = merged_byte;
            out_next.out_last = cur_item.last_byte;
            if (cur_item.last_byte)
            begin
                pos_next         = '0;
                value_ready_next = 1'b0;
            end
            else if (pos_reg != POS_W'(MAX_HEADER_BYTES - 1))
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cfg_reg         <= CFG_RESET;
            pos_reg         <= '0;
            value_ready_reg <= 1'b0;
            lfsr_reg        <= LFSR_SEED;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cfg_reg         <= cfg_next;
            pos_reg         <= pos_next;
            value_ready_reg <= value_ready_next;
            lfsr_reg        <= lfsr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept)
        begin
            item_reg <= src_item;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_reg;

    `PFM_ASSERT_ALWAYS(a_top_onehot, $onehot(state_reg), "top state not one-hot")
    `PFM_ASSERT_SAME(a_no_value_in_calc, state_reg == ST_CALC, !value_ready_reg,
        "field value marked ready while it is being computed")
    `PFM_ASSERT_SAME(a_done_in_calc, calc_done, state_reg == ST_CALC,
        "sequencer finished outside the compute state")
    `PFM_ASSERT_NEXT(a_direct_result, accept && value_ready_reg && slot_free, dst_valid,
        "mid-frame byte did not reach the output register")

endmodule

[tb/packet_field_modifier_checker.sv]
// Checker for the packet field modifier: watches the input, output and register
// transfers, predicts every output byte and compares it with what the block sends.
// Depends on pfm_pkg for the payload types, register indexes and codes.
module packet_field_modifier_checker #(
    parameter int unsigned MAX_HEADER_BYTES = 2048
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    input  logic               src_stall,
    input  pfm_pkg::in_item_t  src_item,
    input  logic               dst_valid,
    input  logic               dst_stall,
    input  pfm_pkg::out_item_t dst_item,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 failures,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfm_pkg::*;

    cfg_t        regs;
    logic [10:0] byte_pos;
    logic [31:0] field_value;
    logic        value_latched;
    logic [31:0] lfsr;
    out_item_t   expected_bytes[$];
    out_item_t   oldest;

    function automatic int unsigned field_size(logic [1:0] sel);
        case (sel)
            WIDTH_8BIT:  return 1;
            WIDTH_16BIT: return 2;
            WIDTH_32BIT: return 4;
            default:     return 0;
        endcase
    endfunction

    function automatic out_item_t rewrite_byte(in_item_t item);
        int unsigned nbytes;
        int unsigned hlen;
        int unsigned offset;
        int unsigned sh;
        logic [31:0] count;
        logic [31:0] span;
        logic [31:0] base;
        logic [31:0] width_bits;
        logic [7:0]  m;
        logic [7:0]  nv;
        out_item_t   res;
        nbytes = field_size(regs.field_width_sel);
        hlen = (regs.header_length > MAX_HEADER_BYTES) ? MAX_HEADER_BYTES
                                                      : regs.header_length;
        offset = regs.field_offset;
        // The new field value is fixed at the first byte of each frame.
        if (!value_latched) begin
            count = (regs.repeat_count == 32'd0) ? 32'd1 : regs.repeat_count;
            span = ({1'b0, item.frame_index} % count) * regs.step_size;
            lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
            case (regs.vary_mode)
                MODE_INCREMENT: base = regs.start_value + span;
                MODE_DECREMENT: base = regs.start_value - span;
                default:        base = regs.start_value + lfsr;
            endcase
            width_bits = (nbytes >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nbytes)) - 32'd1);
            field_value = base & regs.field_mask & width_bits;
            value_latched = 1'b1;
        end
        res.out_byte = item.data_byte;
        res.out_last = item.last_byte;
        if (nbytes != 0 && regs.vary_mode != MODE_NONE && offset + nbytes <= hlen &&
            byte_pos >= offset && byte_pos < offset + nbytes) begin
            sh = 8 * (nbytes - 1 - (byte_pos - offset));
            m = 8'(regs.field_mask >> sh);
            nv = 8'(field_value >> sh);
            res.out_byte = (item.data_byte & ~m) | (nv & m);
        end
        if (item.last_byte) begin
            byte_pos = '0;
            value_latched = 1'b0;
        end
        else if (byte_pos < MAX_HEADER_BYTES - 1) begin
            byte_pos = byte_pos + 11'd1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            regs = CFG_RESET;
            byte_pos = '0;
            field_value = '0;
            value_latched = 1'b0;
            lfsr = LFSR_SEED;
            expected_bytes.delete();
            failures = 0;
            pending = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FIELD_OFFSET:    regs.field_offset = cfg_data[10:0];
                    REG_FIELD_WIDTH_SEL: regs.field_width_sel = cfg_data[1:0];
                    REG_VARY_MODE:       regs.vary_mode = cfg_data[1:0];
                    REG_START_VALUE:     regs.start_value = cfg_data;
                    REG_STEP_SIZE:       regs.step_size = cfg_data;
                    REG_REPEAT_COUNT:    regs.repeat_count = cfg_data;
                    REG_FIELD_MASK:      regs.field_mask = cfg_data;
                    REG_HEADER_LENGTH:   regs.header_length = cfg_data[11:0];
                    default: ;
                endcase
            end
            if (src_valid && !src_stall) begin
                expected_bytes.push_back(rewrite_byte(src_item));
            end
            if (dst_valid && !dst_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("Output transfer with nothing expected: out_byte %02h out_last %0b",
                           dst_item.out_byte, dst_item.out_last);
                    failures++;
                end
                else begin
                    oldest = expected_bytes.pop_front();
                    if (dst_item.out_byte !== oldest.out_byte) begin
                        $error("out_byte: expected %02h, actual %02h",
                               oldest.out_byte, dst_item.out_byte);
                        failures++;
                    end
                    if (dst_item.out_last !== oldest.out_last) begin
                        $error("out_last: expected %0b, actual %0b",
                               oldest.out_last, dst_item.out_last);
                        failures++;
                    end
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

[tb/packet_field_modifier_test.sv]
// Top of the packet field modifier testbench: clock, reset, register writes and header
// byte traffic with random idling; the checker module judges the output transfers.
// Depends on pfm_pkg, packet_field_modifier and packet_field_modifier_checker.
module packet_field_modifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfm_pkg::*;

    localparam int unsigned ITEM_TARGET = 1850;
    localparam int unsigned QUIET_TAIL = 300;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned HOLD_FRAME_BYTES = 40;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    in_item_t    src_item;
    logic        dst_valid;
    logic        dst_stall;
    out_item_t   dst_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    int          failures;
    int          pending;
    int unsigned items_sent = 0;
    bit          src_idle_on = 1'b0;
    bit          sink_idle_on = 1'b0;
    bit          hold_request = 1'b0;

    always #5 clk = ~clk;

    packet_field_modifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    packet_field_modifier_checker field_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    // The output side stalls in random bursts, and once holds off for a long stretch.
    initial
    begin
        dst_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                dst_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                dst_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                dst_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                dst_stall <= 1'b0;
            end
        end
    end

    task automatic put_byte(input in_item_t item);
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item <= item;
        do @(posedge clk); while (src_stall);
        items_sent++;
    endtask

    // Only the first byte's frame index counts; later bytes carry random ones.
    task automatic put_frame(input int unsigned len, input logic [30:0] frame, input bit close);
        in_item_t item;
        for (int unsigned i = 0; i < len; i++) begin
            item.data_byte = 8'($urandom);
            item.frame_index = (i == 0) ? frame : 31'($urandom);
            item.last_byte = close && (i == len - 1);
            put_byte(item);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t s);
        logic [31:0] data;
        for (int i = 0; i < 8; i++) begin
            case (3'(i))
                REG_FIELD_OFFSET:    data = 32'(s.field_offset);
                REG_FIELD_WIDTH_SEL: data = 32'(s.field_width_sel);
                REG_VARY_MODE:       data = 32'(s.vary_mode);
                REG_START_VALUE:     data = s.start_value;
                REG_STEP_SIZE:       data = s.step_size;
                REG_REPEAT_COUNT:    data = s.repeat_count;
                REG_FIELD_MASK:      data = s.field_mask;
                default:             data = 32'(s.header_length);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= data;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word(input int unsigned small_max);
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(0, small_max);
            default: return $urandom;
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        case ($urandom_range(0, 19))
            0:       s.header_length = 12'd0;
            1:       s.header_length = 12'($urandom_range(2049, 4095));
            2:       s.header_length = 12'd2048;
            default: s.header_length = 12'($urandom_range(1, 40));
        endcase
        s.field_width_sel = ($urandom_range(0, 9) == 0) ? WIDTH_NONE
                          : 2'($urandom_range(WIDTH_8BIT, WIDTH_32BIT));
        s.vary_mode = ($urandom_range(0, 9) == 0) ? MODE_NONE
                    : 2'($urandom_range(MODE_INCREMENT, MODE_RANDOM));
        s.field_offset = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                       : 11'($urandom_range(0, 36));
        s.start_value = $urandom;
        s.step_size = pick_word(3);
        s.repeat_count = pick_word(12);
        s.field_mask = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
        return s;
    endfunction

    initial
    begin
        cfg_t          s;
        int unsigned   frame_len;
        int unsigned   frames;
        int unsigned   random_start;
        logic [30:0]   frame;
        bit            paused_once;
        rst_n <= 1'b0;
        src_valid <= 1'b0;
        src_item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        paused_once = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset no field is selected, so every byte passes unchanged.
        put_frame(3, 31'd0, 1'b1);
        src_valid <= 1'b0;
        wait_drained();

        // One-byte header, count of zero taken as one.
        s = CFG_RESET;
        s.field_width_sel = WIDTH_8BIT;
        s.header_length = 12'd1;
        s.start_value = 32'hFFFF_FFFF;
        s.repeat_count = 32'd0;
        load_settings(s);
        put_byte('{data_byte: 8'h00, frame_index: 31'h7FFF_FFFF, last_byte: 1'b1});
        put_byte('{data_byte: 8'hFF, frame_index: 31'h0, last_byte: 1'b1});
        src_valid <= 1'b0;
        wait_drained();

        // 32-bit decrement with the largest step and count under a partial mask.
        s = CFG_RESET;
        s.field_offset = 11'd2;
        s.field_width_sel = WIDTH_32BIT;
        s.vary_mode = MODE_DECREMENT;
        s.start_value = 32'd5;
        s.step_size = 32'hFFFF_FFFF;
        s.repeat_count = 32'hFFFF_FFFF;
        s.field_mask = 32'hF0F0_F0F0;
        s.header_length = 12'd6;
        load_settings(s);
        put_frame(6, 31'h7FFF_FFFF, 1'b1);
        src_valid <= 1'b0;
        wait_drained();

        // Random mode on a 16-bit field, then the mode that leaves the field unchanged.
        s = CFG_RESET;
        s.field_offset = 11'd1;
        s.field_width_sel = WIDTH_16BIT;
        s.vary_mode = MODE_RANDOM;
        s.header_length = 12'd3;
        load_settings(s);
        put_frame(3, 31'd1, 1'b1);
        put_frame(3, 31'd2, 1'b1);
        src_valid <= 1'b0;
        wait_drained();
        s.vary_mode = MODE_NONE;
        load_settings(s);
        put_frame(3, 31'd3, 1'b1);
        src_valid <= 1'b0;
        wait_drained();

        // A header length of zero leaves no room for any field.
        s = CFG_RESET;
        s.field_width_sel = WIDTH_8BIT;
        s.header_length = 12'd0;
        load_settings(s);
        put_frame(2, 31'd4, 1'b1);
        src_valid <= 1'b0;
        wait_drained();

        // Registers change in the middle of a frame.
        s = CFG_RESET;
        s.field_offset = 11'd1;
        s.field_width_sel = WIDTH_8BIT;
        s.start_value = 32'h0000_00A5;
        s.header_length = 12'd4;
        load_settings(s);
        put_frame(2, 31'd9, 1'b0);
        src_valid <= 1'b0;
        wait_drained();
        s.field_offset = 11'd2;
        s.field_mask = 32'h0000_000F;
        s.start_value = 32'h0000_003C;
        load_settings(s);
        put_frame(2, 31'd10, 1'b1);
        src_valid <= 1'b0;
        wait_drained();

        // The output side holds off long enough to fill the block while the
        // sender keeps offering the bytes of one frame.
        s = random_settings();
        load_settings(s);
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        hold_request = 1'b1;
        put_frame(HOLD_FRAME_BYTES, 31'($urandom), 1'b1);
        src_valid <= 1'b0;
        wait_drained();

        random_start = items_sent;
        while (items_sent - random_start < ITEM_TARGET) begin
            if (items_sent - random_start + QUIET_TAIL >= ITEM_TARGET) begin
                src_idle_on = 1'b0;
                sink_idle_on = 1'b0;
            end
            else begin
                src_idle_on = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            s = random_settings();
            load_settings(s);
            frames = $urandom_range(2, 8);
            frame = 31'($urandom);
            for (int unsigned f = 0; f < frames; f++) begin
                if (s.header_length == 12'd0) begin
                    frame_len = $urandom_range(1, 8);
                end
                else if ($urandom_range(0, 3) != 0) begin
                    frame_len = (s.header_length > 12'd48) ? 48 : s.header_length;
                end
                else begin
                    frame_len = $urandom_range(1, 50);
                end
                put_frame(frame_len, frame, 1'b1);
                frame = ($urandom_range(0, 4) == 0) ? 31'($urandom) : frame + 31'd1;
                if (!paused_once && f == 1) begin
                    src_valid <= 1'b0;
                    wait_drained();
                    paused_once = 1'b1;
                end
            end
            src_valid <= 1'b0;
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (pending != 0) begin
            $error("%0d expected output transfers never arrived", pending);
        end
        if (failures == 0 && pending == 0) begin
            $display("CHECK OK");
        end
        else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
